FILE: rtl/asn1_time_string_parser_assert.svh
// assertion macros for the time string parser
`ifndef ASN1_TIME_STRING_PARSER_ASSERT_SVH
`define ASN1_TIME_STRING_PARSER_ASSERT_SVH

// checked only while out of reset
`define ASN1TS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASN1TS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/asn1ts_pkg.sv
`default_nettype none

package asn1ts_pkg;

    localparam logic [7:0] TAG_UTC    = 8'h17;
    localparam logic [7:0] TAG_GEN    = 8'h18;
    localparam logic [7:0] ZULU       = 8'h5A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [3:0] DIGITS_UTC = 4'd14 - 4'd2;
    localparam logic [3:0] DIGITS_GEN = 4'd14;
    localparam logic [3:0] POS_MAX    = 4'd15;

    localparam int PAIR_COUNT = 7;
    localparam int PAIR_W     = 7;
    localparam int RESULT_W   = 41;
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [13:0] BASE_2000    = 14'd2000;
    localparam logic [13:0] BASE_1900    = 14'd1900;
    localparam logic [13:0] CENTURY_MUL  = 14'd100;
    localparam logic [6:0]  PIVOT_YEAR   = 7'd50;
    localparam logic [6:0]  CENTURY_20   = 7'd20;
    localparam logic [6:0]  HOUR_MAX     = 7'd23;
    localparam logic [6:0]  MINSEC_MAX   = 7'd59;

    typedef logic [PAIR_W-1:0] pair_t;
    typedef pair_t [PAIR_COUNT-1:0] pairs_t;

    // element summary handed from the state tracker to the checker
    typedef struct packed {
        logic err;
        logic long_form;
    } close_info_t;

    typedef struct packed {
        logic        status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

    function automatic logic [4:0] month_days(input logic [6:0] mo, input logic leap);
        logic [4:0] lim;
        case (mo)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                   lim = 5'd30;
            7'd2:                                      lim = leap ? 5'd29 : 5'd28;
            default:                                   lim = 5'd0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/asn1ts_state.sv
`default_nettype none

module asn1ts_state
    import asn1ts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        go,
    input  wire logic [7:0]  tag,
    input  wire logic [7:0]  data,
    input  wire logic        last,
    output close_info_t      closing,
    output pairs_t           pairs
);

    logic [3:0] pos_reg, pos_next;
    logic       long_reg, long_next;
    logic       err_reg, err_next;
    pairs_t     pairs_reg;

    logic       first;
    logic       long_eff;
    logic       err_start;
    logic [3:0] ndig;
    logic       is_digit;
    logic [3:0] digit;
    logic [2:0] idx;
    pair_t      pair_old;
    pair_t      pair_new;
    logic       pair_we;
    logic [10:0] times_ten;

    always_comb begin
        first     = (pos_reg == 4'd0);
        long_eff  = first ? (tag == TAG_GEN) : long_reg;
        err_start = err_reg | (first & (tag != TAG_GEN) & (tag != TAG_UTC));
        ndig      = long_eff ? DIGITS_GEN : DIGITS_UTC;
        is_digit  = (data >= ASCII_ZERO) && (data <= ASCII_NINE);
        digit     = 4'(data - ASCII_ZERO);
        idx       = pos_reg[3:1];
        pair_old  = pairs_reg[idx];
        times_ten = 11'(pair_old) * 11'd10 + 11'(digit);
        // even position opens a fresh pair
        pair_new  = pos_reg[0] ? times_ten[PAIR_W-1:0] : PAIR_W'(digit);
        pair_we   = 1'b0;
        err_next  = err_start;
        if (pos_reg < ndig) begin
            if (!is_digit) begin
                err_next = 1'b1;
            end else if (!err_start) begin
                pair_we = 1'b1;
            end
        end else if (pos_reg == ndig) begin
            if (data != ZULU) begin
                err_next = 1'b1;
            end
        end else begin
            err_next = 1'b1;
        end
        closing.err       = err_next | (pos_reg != ndig);
        closing.long_form = long_eff;
        long_next         = long_eff;
        pos_next          = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 4'd0;
            long_reg <= 1'b0;
            err_reg  <= 1'b0;
        end else if (go) begin
            if (last) begin
                pos_reg  <= 4'd0;
                long_reg <= 1'b0;
                err_reg  <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                long_reg <= long_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go && pair_we) begin
            pairs_reg[idx] <= pair_new;
        end
    end

    assign pairs = pairs_reg;

endmodule

`default_nettype wire

FILE: rtl/asn1ts_check.sv
`default_nettype none

module asn1ts_check
    import asn1ts_pkg::*;
(
    input  wire close_info_t closing,
    input  wire pairs_t      pairs,
    output result_t          result
);

    logic [13:0] year;
    pair_t       yy;
    pair_t       cc;
    pair_t       mo;
    pair_t       dd;
    pair_t       hh;
    pair_t       mi;
    pair_t       ss;
    logic        leap;
    logic [4:0]  lim;
    logic        ok;

    always_comb begin
        if (closing.long_form) begin
            year = 14'(pairs[0]) * CENTURY_MUL + 14'(pairs[1]);
            yy   = pairs[1];
            cc   = pairs[0];
            mo   = pairs[2];
            dd   = pairs[3];
            hh   = pairs[4];
            mi   = pairs[5];
            ss   = pairs[6];
        end else begin
            year = 14'(pairs[0]) + ((pairs[0] < PIVOT_YEAR) ? BASE_2000 : BASE_1900);
            yy   = pairs[0];
            cc   = CENTURY_20;
            mo   = pairs[1];
            dd   = pairs[2];
            hh   = pairs[3];
            mi   = pairs[4];
            ss   = pairs[5];
        end
        // century years are leap only when the century divides by four
        leap = ((yy[1:0] == 2'd0) && (yy != '0)) || ((yy == '0) && (cc[1:0] == 2'd0));
        lim  = month_days(mo, leap);
        ok   = !closing.err && (year <= YEAR_MAX) && (lim != 5'd0)
               && (dd != '0) && (dd <= PAIR_W'(lim))
               && (hh <= HOUR_MAX) && (mi <= MINSEC_MAX) && (ss <= MINSEC_MAX);
        result = '0;
        if (ok) begin
            result.year   = year;
            result.month  = mo[3:0];
            result.day    = dd[4:0];
            result.hour   = hh[4:0];
            result.minute = mi[5:0];
            result.second = ss[5:0];
        end else begin
            result.status = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/asn1_time_string_parser.sv
// asn1 time string parser: one content byte per transfer, one result per element
// an accepted last byte passes the input register, then the result register, to m_tvalid;
// a held result stalls that closing byte in the input register
// throughput: one byte per cycle, a closing byte waiting only while a result is held
// reset: aresetn low clears both stage valids and the element tracking state
`default_nettype none

`include "asn1_time_string_parser_assert.svh"

module asn1_time_string_parser
    import asn1ts_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // data_byte
    input  wire logic [7:0]             s_tuser,   // element_tag
    input  wire logic                   s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata    // status, year, month, day, hour,
                                                   // minute, second, zero pad
);

    // input register stage
    logic       in_valid_reg;
    logic [7:0] in_tag_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register stage
    logic                   m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;

    logic        out_free;
    logic        proc_go;
    logic        close_go;
    close_info_t closing;
    pairs_t      pairs;
    result_t     result;

    // result views watched by the checks at the end
    logic                res_bad;
    logic                res_good;
    logic [RESULT_W-2:0] res_fields;
    logic                res_month_ok;
    logic                res_hour_ok;
    logic                any_valid;

    // a non-last byte only touches state, so it never waits on the result side
    assign out_free = !m_tvalid_reg || m_tready;
    assign proc_go  = in_valid_reg && (!in_last_reg || out_free);
    assign close_go = proc_go && in_last_reg;
    assign s_tready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tag_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // per-element position, tag form, error flag and digit pairs
    asn1ts_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (proc_go),
        .tag     (in_tag_reg),
        .data    (in_byte_reg),
        .last    (in_last_reg),
        .closing (closing),
        .pairs   (pairs)
    );

    // year mapping and calendar / clock range checks on the closing byte
    asn1ts_check u_check (
        .closing (closing),
        .pairs   (pairs),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (close_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (close_go) begin
            m_tdata_reg <= TDATA_OUT_W'({result.second, result.minute, result.hour,
                                         result.day, result.month, result.year,
                                         result.status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign res_bad      = m_tvalid_reg && m_tdata_reg[0];
    assign res_good     = m_tvalid_reg && !m_tdata_reg[0];
    assign res_fields   = m_tdata_reg[RESULT_W-1:1];
    assign res_month_ok = (m_tdata_reg[18:15] != 4'd0) && (m_tdata_reg[18:15] <= 4'd12);
    assign res_hour_ok  = (m_tdata_reg[28:24] <= 5'd23);
    assign any_valid    = m_tvalid_reg || in_valid_reg;

    // an invalid element carries all-zero fields
    `ASN1TS_ASSERT(a_invalid_zero, res_bad |-> res_fields == '0, "invalid with fields")
    // a valid result has a real month and hour
    `ASN1TS_ASSERT(a_valid_range, res_good |-> res_month_ok && res_hour_ok, "out of range")
    // a new result only follows the closing byte of an element
    `ASN1TS_ASSERT(a_result_src, $rose(m_tvalid_reg) |-> $past(close_go), "stray result")
    // nothing is presented right after reset
    `ASN1TS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !any_valid, "valid set after reset")

endmodule

`default_nettype wire
